### hdl/serial_frame_parser_three_mode_assert.svh
// ----------------------------------------------------------------------------
// Serial frame parser assertion macros
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_PARSER_THREE_MODE_ASSERT_SVH
`define SERIAL_FRAME_PARSER_THREE_MODE_ASSERT_SVH

// Same-cycle implication
`define SFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfp: same-cycle check failed");

// Next-cycle implication
`define SFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfp: next-cycle check failed");

`endif

### hdl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame parser package
// Shared types, codes and constants for the three-format frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Limits of the frame formats
  localparam int unsigned DART_MAX_DATA    = 64;
  localparam int unsigned SERVO_MAX_PARAMS = 8;
  localparam int unsigned STORE_DEPTH      = 64;
  localparam int unsigned STORE_AW         = $clog2(STORE_DEPTH);

  localparam logic [7:0] SYNC_BYTE       = 8'h55;
  localparam logic [7:0] SERVO_LEN_MIN   = 8'd2;
  localparam logic [7:0] SERVO_LEN_MAX   = 8'd64;
  localparam logic [7:0] SERVO_ID_LEN_MIN = 8'd3;
  localparam logic [7:0] SERVO_ID_LEN_MAX = 8'd11;
  localparam logic [6:0] POS_LIMIT       = 7'd64;

  // Protocol mode register codes
  localparam logic [1:0] MODE_SERVO    = 2'd0;
  localparam logic [1:0] MODE_SERVO_ID = 2'd1;
  localparam logic [1:0] MODE_DART     = 2'd2;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ID     = 3'd1,
    PH_LENGTH = 3'd2,
    PH_CMD    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_e;

  // Emitter sequencer state
  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_READ = 2'd1,
    EM_SEND = 2'd2
  } em_state_e;

  // Payload store write port
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

  // Frame emission request
  typedef struct packed {
    logic       start;
    logic [7:0] device_id;
    logic [7:0] length_field;
    logic [7:0] command_code;
    logic [6:0] payload_count;
  } emit_req_t;

  // "DART" header characters
  function automatic logic [7:0] dart_magic(input logic [1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      2'd0:    ch = 8'h44;
      2'd1:    ch = 8'h41;
      2'd2:    ch = 8'h52;
      default: ch = 8'h54;
    endcase
    return ch;
  endfunction

endpackage

### hdl/sfp_rx_if.sv
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one serial byte per transaction.
// ----------------------------------------------------------------------------
interface sfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hdl/sfp_res_if.sv
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying one payload result per transaction.
// ----------------------------------------------------------------------------
interface sfp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] device_id;
  logic [7:0] length_field;
  logic [7:0] command_code;
  logic [6:0] payload_count;
  logic       payload_valid;
  logic [5:0] payload_index;
  logic [7:0] payload_value;
  logic       last_of_frame;

  modport source (
    output valid, output device_id, output length_field, output command_code,
    output payload_count, output payload_valid, output payload_index,
    output payload_value, output last_of_frame, input ready
  );
  modport sink (
    input valid, input device_id, input length_field, input command_code,
    input payload_count, input payload_valid, input payload_index,
    input payload_value, input last_of_frame, output ready
  );
endinterface

### hdl/sfp_emitter.sv
// ----------------------------------------------------------------------------
// Frame emitter
// Payload store plus a sequencer that replays a checked frame as results.
// ----------------------------------------------------------------------------
module sfp_emitter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfp_pkg::store_wr_t    wr_i,
  input  sfp_pkg::emit_req_t    req_i,
  output logic                  busy_o,
  sfp_res_if.source             res_o
);
  import sfp_pkg::*;

  logic [7:0] store_q [STORE_DEPTH];
  logic [7:0] rd_q;

  em_state_e state_q, state_d;
  logic [STORE_AW-1:0] idx_q, idx_d;
  emit_req_t hdr_q;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_id_q, out_len_q, out_cmd_q, out_val_q;
  logic [6:0] out_cnt_q;
  logic       out_pv_q, out_last_q;
  logic [5:0] out_idx_q;

  logic load;
  logic last_item;
  logic slot_free;

  // Payload store: written by the parser, read one entry per result
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      store_q[wr_i.addr] <= wr_i.data;
    end
    if (state_q == EM_READ) begin
      rd_q <= store_q[idx_q];
    end
  end

  assign slot_free = !out_valid_q || res_o.ready;
  assign last_item = (hdr_q.payload_count == 7'd0) ||
                     (({1'b0, idx_q} + 7'd1) == hdr_q.payload_count);

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    load        = 1'b0;
    out_valid_d = out_valid_q && !res_o.ready;
    unique case (state_q)
      EM_IDLE: begin
        if (req_i.start) begin
          idx_d   = '0;
          state_d = (req_i.payload_count == 7'd0) ? EM_SEND : EM_READ;
        end
      end
      EM_READ: begin
        state_d = EM_SEND;
      end
      EM_SEND: begin
        if (slot_free) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          if (last_item) begin
            state_d = EM_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = EM_READ;
          end
        end
      end
      default: begin
        state_d = EM_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EM_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Frame header latch and output slot
  always_ff @(posedge clk_i) begin
    if (state_q == EM_IDLE && req_i.start) begin
      hdr_q <= req_i;
    end
    if (load) begin
      out_id_q   <= hdr_q.device_id;
      out_len_q  <= hdr_q.length_field;
      out_cmd_q  <= hdr_q.command_code;
      out_cnt_q  <= hdr_q.payload_count;
      out_pv_q   <= (hdr_q.payload_count != 7'd0);
      out_idx_q  <= idx_q;
      out_val_q  <= (hdr_q.payload_count != 7'd0) ? rd_q : 8'd0;
      out_last_q <= last_item;
    end
  end

  assign busy_o              = (state_q != EM_IDLE);
  assign res_o.valid         = out_valid_q;
  assign res_o.device_id     = out_id_q;
  assign res_o.length_field  = out_len_q;
  assign res_o.command_code  = out_cmd_q;
  assign res_o.payload_count = out_cnt_q;
  assign res_o.payload_valid = out_pv_q;
  assign res_o.payload_index = out_idx_q;
  assign res_o.payload_value = out_val_q;
  assign res_o.last_of_frame = out_last_q;

endmodule

### hdl/serial_frame_parser_three_mode.sv
// ----------------------------------------------------------------------------
// Serial frame parser, three formats
// One byte is taken per cycle, but input is held off while a frame's results
// are replayed. Each result takes a payload store read and then a load into
// the output slot, which waits for a free slot; an empty payload skips the read.
// Reset: DART format, header search; the payload store is not cleared.
// ----------------------------------------------------------------------------
module serial_frame_parser_three_mode (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  sfp_rx_if.sink     rx_i,
  sfp_res_if.source  res_o
);
  import sfp_pkg::*;

  `include "serial_frame_parser_three_mode_assert.svh"

  logic [1:0] mode_q, mode_d;
  phase_e     phase_q, phase_d;
  logic [6:0] pos_q, pos_d;
  logic [7:0] id_q, id_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] sum_q, sum_d;

  logic       em_busy;
  emit_req_t  req;
  store_wr_t  wr;

  logic       rx_fire;
  logic       drop;
  logic [1:0] mode_eff;
  logic [7:0] b;
  logic [7:0] plen;
  logic [6:0] pay_n;
  logic [7:0] sum_add;
  logic [7:0] pos_inc;
  logic [7:0] pos_ext;

  assign rx_i.ready = !em_busy;
  assign rx_fire    = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign mode_eff   = (mode_q == MODE_SERVO || mode_q == MODE_SERVO_ID) ? mode_q : MODE_DART;

  // Shared byte adder for the running checksum
  assign sum_add = sum_q + b;
  assign pos_ext = {1'b0, pos_q};
  assign pos_inc = pos_ext + 8'd1;

  // Payload length from the held length byte
  always_comb begin
    unique case (mode_eff)
      MODE_SERVO:    plen = (len_q >= SERVO_LEN_MIN) ? len_q - SERVO_LEN_MIN : 8'd0;
      MODE_SERVO_ID: plen = (len_q >= SERVO_ID_LEN_MIN) ? len_q - SERVO_ID_LEN_MIN : 8'd0;
      default:       plen = len_q;
    endcase
    pay_n = (plen > {1'b0, POS_LIMIT}) ? POS_LIMIT : plen[6:0];
  end

  // Parser next state
  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    pos_d   = pos_q;
    id_d    = id_q;
    len_d   = len_q;
    cmd_d   = cmd_q;
    sum_d   = sum_q;
    drop    = 1'b0;
    wr      = '0;
    req     = '0;
    req.device_id     = (mode_eff == MODE_SERVO_ID) ? id_q : 8'd0;
    req.length_field  = len_q;
    req.command_code  = (mode_eff == MODE_DART) ? 8'd0 : cmd_q;
    req.payload_count = pay_n;
    wr.addr = pos_q[STORE_AW-1:0];
    wr.data = b;

    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
      drop   = 1'b1;
    end else if (rx_fire) begin
      if (mode_eff == MODE_DART) begin
        // DART framing
        unique case (phase_q)
          PH_HEADER: begin
            if (pos_q < 7'd4 && b == dart_magic(pos_q[1:0])) begin
              if (pos_inc == 8'd4) begin
                phase_d = PH_LENGTH;
                pos_d   = '0;
              end else begin
                pos_d = pos_inc[6:0];
              end
            end else begin
              drop = 1'b1;
            end
          end
          PH_LENGTH: begin
            len_d = b;
            if (b <= 8'(DART_MAX_DATA)) begin
              phase_d = (b == 8'd0) ? PH_CHECK : PH_DATA;
              pos_d   = '0;
              sum_d   = '0;
            end else begin
              drop = 1'b1;
            end
          end
          PH_DATA: begin
            if (pos_ext < len_q && pos_q < POS_LIMIT) begin
              wr.we = 1'b1;
              sum_d = sum_add;
              pos_d = pos_inc[6:0];
              if (pos_inc >= len_q) begin
                phase_d = PH_CHECK;
                pos_d   = '0;
              end
            end else begin
              drop = 1'b1;
            end
          end
          PH_CHECK: begin
            if (~sum_q == b) begin
              req.start = 1'b1;
              phase_d   = PH_HEADER;
              pos_d     = '0;
            end else begin
              drop = 1'b1;
            end
          end
          default: begin
            drop = 1'b1;
          end
        endcase
      end else begin
        // Servo framing
        unique case (phase_q)
          PH_HEADER: begin
            if (pos_q == 7'd0) begin
              if (b == SYNC_BYTE) begin
                pos_d = 7'd1;
              end
            end else if (pos_q == 7'd1 && b == SYNC_BYTE) begin
              phase_d = (mode_eff == MODE_SERVO_ID) ? PH_ID : PH_LENGTH;
              pos_d   = '0;
              sum_d   = '0;
            end else begin
              drop = 1'b1;
            end
          end
          PH_ID: begin
            if (mode_eff == MODE_SERVO_ID) begin
              id_d    = b;
              sum_d   = b;
              phase_d = PH_LENGTH;
            end else begin
              drop = 1'b1;
            end
          end
          PH_LENGTH: begin
            len_d = b;
            if ((mode_eff == MODE_SERVO && b >= SERVO_LEN_MIN && b <= SERVO_LEN_MAX) ||
                (mode_eff == MODE_SERVO_ID && b >= SERVO_ID_LEN_MIN &&
                 b <= SERVO_ID_LEN_MAX)) begin
              sum_d   = sum_add;
              phase_d = PH_CMD;
            end else begin
              drop = 1'b1;
            end
          end
          PH_CMD: begin
            cmd_d = b;
            sum_d = sum_add;
            pos_d = '0;
            if (plen != 8'd0) begin
              phase_d = PH_DATA;
            end else if (mode_eff == MODE_SERVO_ID) begin
              phase_d = PH_CHECK;
            end else begin
              req.command_code = b;
              req.start        = 1'b1;
              phase_d          = PH_HEADER;
            end
          end
          PH_DATA: begin
            if (pos_ext < plen && pos_ext < 8'(SERVO_MAX_PARAMS)) begin
              wr.we = 1'b1;
              sum_d = sum_add;
              pos_d = pos_inc[6:0];
              if (pos_inc >= plen) begin
                if (mode_eff == MODE_SERVO_ID) begin
                  phase_d = PH_CHECK;
                end else begin
                  req.start = 1'b1;
                  phase_d   = PH_HEADER;
                  pos_d     = '0;
                end
              end
            end else begin
              drop = 1'b1;
            end
          end
          PH_CHECK: begin
            if (mode_eff == MODE_SERVO_ID && ~sum_q == b) begin
              req.start = 1'b1;
              phase_d   = PH_HEADER;
              pos_d     = '0;
            end else begin
              drop = 1'b1;
            end
          end
          default: begin
            drop = 1'b1;
          end
        endcase
      end
    end

    // Frame dropped: back to header search
    if (drop) begin
      phase_d = PH_HEADER;
      pos_d   = '0;
      id_d    = '0;
      len_d   = '0;
      cmd_d   = '0;
      sum_d   = '0;
    end
  end

  // Parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_DART;
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      id_q    <= '0;
      len_q   <= '0;
      cmd_q   <= '0;
      sum_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
      id_q    <= id_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      sum_q   <= sum_d;
    end
  end

  // Payload store and result sequencer
  sfp_emitter u_emitter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .req_i  (req),
    .busy_o (em_busy),
    .res_o  (res_o)
  );

  // Checks
  `SFP_ASSERT_SAME(a_start_on_byte, clk_i, rst_ni, req.start, rx_fire)
  `SFP_ASSERT_NEXT(a_hold_after_start, clk_i, rst_ni, req.start, !rx_i.ready)
  `SFP_ASSERT_SAME(a_pos_in_store, clk_i, rst_ni, phase_q == PH_DATA, pos_q < POS_LIMIT)

endmodule

### bench/sfp_frame_checker.sv
// ----------------------------------------------------------------------------
// Serial frame parser checker
// Watches the byte and result channels, keeps its own model of the three
// frame formats, and compares every result transaction with the oldest
// predicted result.
// ----------------------------------------------------------------------------
module sfp_frame_checker
  import sfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  sfp_rx_if           rx_i,
  sfp_res_if          res_i,
  output int unsigned pending_o,
  output int unsigned mismatch_count_o
);

  localparam logic [31:0] DART_TAG    = 32'h4441_5254;  // "DART"
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    logic [7:0] device_id;
    logic [7:0] length_field;
    logic [7:0] command_code;
    logic [6:0] payload_count;
    logic       payload_valid;
    logic [5:0] payload_index;
    logic [7:0] payload_value;
    logic       last_of_frame;
  } frame_result_t;

  // Parser state of the model
  logic [1:0]    fmt_reg;
  phase_e        cur_phase;
  logic [6:0]    byte_pos;
  logic [7:0]    frame_id;
  logic [7:0]    frame_len;
  logic [7:0]    frame_cmd;
  logic [7:0]    csum;
  logic [7:0]    param_mem [STORE_DEPTH];
  frame_result_t frame_results_q [$];

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count_o < PRINT_LIMIT)
      $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatch_count_o++;
  endtask

  task automatic clear_frame();
    cur_phase = PH_HEADER;
    byte_pos  = '0;
    frame_id  = '0;
    frame_len = '0;
    frame_cmd = '0;
    csum      = '0;
  endtask

  // Number of parameter or data bytes implied by the length byte
  function automatic logic [7:0] param_count(input logic [1:0] fmt);
    logic [7:0] n;
    if (fmt == MODE_SERVO)
      n = (frame_len >= 8'd2) ? frame_len - 8'd2 : 8'd0;
    else if (fmt == MODE_SERVO_ID)
      n = (frame_len >= 8'd3) ? frame_len - 8'd3 : 8'd0;
    else
      n = frame_len;
    return n;
  endfunction

  // Queue the result run of a finished frame
  task automatic emit_frame(input logic [1:0] fmt);
    logic [7:0]    n;
    frame_result_t r;
    n = param_count(fmt);
    if (n > 8'd64)
      n = 8'd64;
    r.device_id    = (fmt == MODE_SERVO_ID) ? frame_id : 8'h00;
    r.length_field = frame_len;
    r.command_code = (fmt == MODE_DART) ? 8'h00 : frame_cmd;
    if (n == 8'd0) begin
      r.payload_count = '0;
      r.payload_valid = 1'b0;
      r.payload_index = '0;
      r.payload_value = '0;
      r.last_of_frame = 1'b1;
      frame_results_q.push_back(r);
    end else begin
      for (int k = 0; k < n; k++) begin
        r.payload_count = n[6:0];
        r.payload_valid = 1'b1;
        r.payload_index = k[5:0];
        r.payload_value = param_mem[k];
        r.last_of_frame = (k == n - 1);
        frame_results_q.push_back(r);
      end
    end
  endtask

  // Servo formats, with or without id and checksum
  task automatic servo_byte(input logic [1:0] fmt, input logic [7:0] b);
    logic [7:0] n;
    logic [7:0] csum_inv;
    case (cur_phase)
      PH_HEADER: begin
        if (byte_pos == 7'd0) begin
          if (b == SYNC_BYTE)
            byte_pos = 7'd1;
        end else if (byte_pos == 7'd1 && b == SYNC_BYTE) begin
          if (fmt == MODE_SERVO_ID)
            cur_phase = PH_ID;
          else
            cur_phase = PH_LENGTH;
          byte_pos = '0;
          csum     = '0;
        end else begin
          clear_frame();
        end
      end
      PH_ID: begin
        if (fmt != MODE_SERVO_ID) begin
          clear_frame();
        end else begin
          frame_id  = b;
          csum      = b;
          cur_phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        frame_len = b;
        if ((fmt == MODE_SERVO && b >= SERVO_LEN_MIN && b <= SERVO_LEN_MAX) ||
            (fmt == MODE_SERVO_ID && b >= SERVO_ID_LEN_MIN && b <= SERVO_ID_LEN_MAX)) begin
          csum      = csum + b;
          cur_phase = PH_CMD;
        end else begin
          clear_frame();
        end
      end
      PH_CMD: begin
        frame_cmd = b;
        csum      = csum + b;
        byte_pos  = '0;
        if (param_count(fmt) > 8'd0) begin
          cur_phase = PH_DATA;
        end else if (fmt == MODE_SERVO_ID) begin
          cur_phase = PH_CHECK;
        end else begin
          emit_frame(fmt);
          cur_phase = PH_HEADER;
          byte_pos  = '0;
        end
      end
      PH_DATA: begin
        n = param_count(fmt);
        if (byte_pos < n && byte_pos < SERVO_MAX_PARAMS) begin
          param_mem[byte_pos[5:0]] = b;
          csum     = csum + b;
          byte_pos = byte_pos + 7'd1;
          if (byte_pos >= n) begin
            if (fmt == MODE_SERVO_ID) begin
              cur_phase = PH_CHECK;
            end else begin
              emit_frame(fmt);
              cur_phase = PH_HEADER;
              byte_pos  = '0;
            end
          end
        end else begin
          // too many parameters for the servo formats
          clear_frame();
        end
      end
      PH_CHECK: begin
        csum_inv = ~csum;
        if (fmt == MODE_SERVO_ID && b == csum_inv) begin
          emit_frame(fmt);
          cur_phase = PH_HEADER;
          byte_pos  = '0;
        end else begin
          clear_frame();
        end
      end
      default: clear_frame();
    endcase
  endtask

  // DART format
  task automatic dart_byte(input logic [7:0] b);
    logic [7:0] csum_inv;
    case (cur_phase)
      PH_HEADER: begin
        if (byte_pos < 7'd4 && b == DART_TAG[8 * (3 - byte_pos[1:0]) +: 8]) begin
          byte_pos = byte_pos + 7'd1;
          if (byte_pos == 7'd4) begin
            cur_phase = PH_LENGTH;
            byte_pos  = '0;
          end
        end else begin
          clear_frame();
        end
      end
      PH_LENGTH: begin
        frame_len = b;
        if (b <= DART_MAX_DATA) begin
          if (b == 8'd0)
            cur_phase = PH_CHECK;
          else
            cur_phase = PH_DATA;
          byte_pos = '0;
          csum     = '0;
        end else begin
          clear_frame();
        end
      end
      PH_DATA: begin
        if (byte_pos < frame_len && byte_pos < STORE_DEPTH) begin
          param_mem[byte_pos[5:0]] = b;
          csum     = csum + b;
          byte_pos = byte_pos + 7'd1;
          if (byte_pos >= frame_len) begin
            cur_phase = PH_CHECK;
            byte_pos  = '0;
          end
        end else begin
          clear_frame();
        end
      end
      PH_CHECK: begin
        csum_inv = ~csum;
        if (b == csum_inv) begin
          emit_frame(MODE_DART);
          cur_phase = PH_HEADER;
          byte_pos  = '0;
        end else begin
          clear_frame();
        end
      end
      default: clear_frame();
    endcase
  endtask

  // Track configuration, byte and result transactions
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_ni) begin
      fmt_reg = MODE_DART;
      clear_frame();
      frame_results_q.delete();
      mismatch_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        fmt_reg = cfg_wdata_i;
        clear_frame();
      end
      if (rx_i.valid && rx_i.ready) begin
        if (fmt_reg == MODE_SERVO || fmt_reg == MODE_SERVO_ID)
          servo_byte(fmt_reg, rx_i.rx_byte);
        else
          dart_byte(rx_i.rx_byte);
      end
      if (res_i.valid && res_i.ready) begin
        got.device_id     = res_i.device_id;
        got.length_field  = res_i.length_field;
        got.command_code  = res_i.command_code;
        got.payload_count = res_i.payload_count;
        got.payload_valid = res_i.payload_valid;
        got.payload_index = res_i.payload_index;
        got.payload_value = res_i.payload_value;
        got.last_of_frame = res_i.last_of_frame;
        if (frame_results_q.size() == 0) begin
          report_mismatch("unexpected result, payload_value", got.payload_value, 0);
        end else begin
          want = frame_results_q.pop_front();
          if (got.device_id !== want.device_id)
            report_mismatch("device_id", got.device_id, want.device_id);
          if (got.length_field !== want.length_field)
            report_mismatch("length_field", got.length_field, want.length_field);
          if (got.command_code !== want.command_code)
            report_mismatch("command_code", got.command_code, want.command_code);
          if (got.payload_count !== want.payload_count)
            report_mismatch("payload_count", got.payload_count, want.payload_count);
          if (got.payload_valid !== want.payload_valid)
            report_mismatch("payload_valid", got.payload_valid, want.payload_valid);
          if (got.payload_index !== want.payload_index)
            report_mismatch("payload_index", got.payload_index, want.payload_index);
          if (got.payload_value !== want.payload_value)
            report_mismatch("payload_value", got.payload_value, want.payload_value);
          if (got.last_of_frame !== want.last_of_frame)
            report_mismatch("last_of_frame", got.last_of_frame, want.last_of_frame);
        end
      end
      pending_o <= frame_results_q.size();
    end
  end

endmodule

### bench/serial_frame_parser_three_mode_tb.sv
// ----------------------------------------------------------------------------
// Serial frame parser testbench
// Feeds framed and corrupted byte streams in all three formats, with random
// gaps and back-pressure, and leaves the checking to the frame checker.
// ----------------------------------------------------------------------------
module serial_frame_parser_three_mode_tb;
  import sfp_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_BYTES = 170;
  localparam int unsigned SETTLE_WAIT  = 8;
  // mode value 3 is not named by the block; it acts as DART
  localparam logic [1:0]  MODE_DART_ALT = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  int unsigned results_pending;
  int unsigned mismatch_count;
  int unsigned bytes_sent;
  logic        quiet_run;
  logic        hold_request;
  logic [7:0]  frame_bytes [$];

  sfp_rx_if  rx_ch ();
  sfp_res_if res_ch ();

  serial_frame_parser_three_mode u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_i       (rx_ch),
    .res_o      (res_ch)
  );

  sfp_frame_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_i            (rx_ch),
    .res_i           (res_ch),
    .pending_o       (results_pending),
    .mismatch_count_o(mismatch_count)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One byte transaction, after a random gap
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = quiet_run ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= value;
    do @(posedge clk_i); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    logic [7:0] b;
    while (frame_bytes.size() != 0) begin
      b = frame_bytes.pop_front();
      send_byte(b);
    end
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic settle();
    rx_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0)
      @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Append up to eight bytes, most significant first
  task automatic put_raw(input logic [63:0] bytes, input int unsigned count);
    for (int i = count; i > 0; i--)
      frame_bytes.push_back(bytes[8 * (i - 1) +: 8]);
  endtask

  // Servo frame; parameter count follows the length byte, but is 4 for a length over 64 or an id-frame count over eight
  task automatic put_servo(input logic [1:0] fmt, input logic [7:0] len,
                           input logic [7:0] id, input logic [7:0] cmd);
    int unsigned nparam;
    logic [7:0]  sum;
    logic [7:0]  p;
    if (fmt == MODE_SERVO)
      nparam = (len >= 8'd2) ? len - 8'd2 : 0;
    else
      nparam = (len >= 8'd3) ? len - 8'd3 : 0;
    if (len > 8'd64 || (fmt == MODE_SERVO_ID && nparam > SERVO_MAX_PARAMS))
      nparam = 4;
    frame_bytes.push_back(SYNC_BYTE);
    frame_bytes.push_back(SYNC_BYTE);
    if (fmt == MODE_SERVO_ID)
      frame_bytes.push_back(id);
    frame_bytes.push_back(len);
    frame_bytes.push_back(cmd);
    sum = id + len + cmd;
    repeat (nparam) begin
      p = 8'($urandom_range(0, 255));
      frame_bytes.push_back(p);
      sum = sum + p;
    end
    if (fmt == MODE_SERVO_ID)
      frame_bytes.push_back(~sum);
  endtask

  // DART frame; an oversized length gets a little trailing noise instead
  task automatic put_dart(input logic [7:0] len);
    logic [7:0] sum;
    logic [7:0] d;
    put_raw(64'h4441_5254, 4);
    frame_bytes.push_back(len);
    if (len <= DART_MAX_DATA) begin
      sum = '0;
      repeat (len) begin
        d = 8'($urandom_range(0, 255));
        frame_bytes.push_back(d);
        sum = sum + d;
      end
      frame_bytes.push_back(~sum);
    end else begin
      repeat (2) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly good frames with random content, some noise and damage
  task automatic put_random_frame(input logic [1:0] fmt);
    logic [7:0]  len;
    logic [7:0]  flip;
    int unsigned pick;
    int unsigned idx;
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 31);
    case (fmt)
      MODE_SERVO: begin
        if (pick < 26)
          len = 8'($urandom_range(2, 10));
        else if (pick < 29)
          len = 8'($urandom_range(11, 64));
        else if (pick == 29)
          len = 8'($urandom_range(0, 1));
        else
          len = 8'($urandom_range(65, 255));
        put_servo(fmt, len, 8'h00, 8'($urandom_range(0, 255)));
      end
      MODE_SERVO_ID: begin
        if (pick < 28)
          len = 8'($urandom_range(3, 11));
        else if (pick < 30)
          len = 8'($urandom_range(0, 2));
        else
          len = 8'($urandom_range(12, 255));
        put_servo(fmt, len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      default: begin
        if (pick < 26)
          len = 8'($urandom_range(0, 8));
        else if (pick < 28)
          len = 8'($urandom_range(9, 63));
        else if (pick == 28)
          len = 8'(DART_MAX_DATA);
        else
          len = 8'($urandom_range(65, 255));
        put_dart(len);
      end
    endcase
    if ($urandom_range(0, 9) == 0) begin
      idx  = $urandom_range(0, frame_bytes.size() - 1);
      flip = 8'($urandom_range(1, 255));
      frame_bytes[idx] = frame_bytes[idx] ^ flip;
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_drain
    int unsigned gap;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = quiet_run ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // Watchdog: cycles with no transaction on either channel
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL serial_frame_parser_three_mode");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    int unsigned random_start;
    int unsigned phase_no;
    logic [1:0]  mode;
    logic [1:0]  fmt;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= MODE_DART;
    quiet_run     = 1'b0;
    hold_request  = 1'b0;
    bytes_sent    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // DART after reset: empty, one byte, broken tag, oversized length,
    // bad checksum, then single bytes of all ones and all zeros
    put_dart(8'd0);
    put_dart(8'd1);
    put_raw(64'h4441_58, 3);
    put_raw(64'h44_4152_5441, 5);
    put_raw(64'h4441_5254_01FF_01, 7);
    put_raw(64'h4441_5254_01FF_00, 7);
    put_raw(64'h4441_5254_0100_FF, 7);
    send_frame();

    // Servo without checksum: stray bytes, bad second sync byte, empty,
    // full, lengths out of range, one parameter too many
    write_mode(MODE_SERVO);
    put_raw(64'h00FF_5500, 4);
    put_servo(MODE_SERVO, 8'd2, 8'h00, 8'hA5);
    put_servo(MODE_SERVO, 8'd10, 8'h00, 8'h5A);
    put_raw(64'h5555_01, 3);
    put_raw(64'h5555_41, 3);
    put_servo(MODE_SERVO, 8'd11, 8'h00, 8'h3C);
    send_frame();

    // Servo with id: empty, full, bad checksum, lengths out of range
    write_mode(MODE_SERVO_ID);
    put_servo(MODE_SERVO_ID, 8'd3, 8'hFF, 8'h00);
    put_servo(MODE_SERVO_ID, 8'd11, 8'h00, 8'hFF);
    put_servo(MODE_SERVO_ID, 8'd5, 8'h12, 8'h34);
    frame_bytes[frame_bytes.size() - 1] = frame_bytes[frame_bytes.size() - 1] ^ 8'h01;
    put_raw(64'h5555_0702, 4);
    put_raw(64'h5555_070C, 4);
    send_frame();

    // Mode value 3 parses DART
    write_mode(MODE_DART_ALT);
    put_dart(8'd2);
    send_frame();

    // Back-pressure: a full DART frame and three short ones while the result side holds off
    write_mode(MODE_DART);
    hold_request = 1'b1;
    put_dart(8'(DART_MAX_DATA));
    repeat (3) put_dart(8'($urandom_range(1, 4)));
    send_frame();

    // Random phases, each in one format
    random_start = bytes_sent;
    phase_no     = 0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      mode = (phase_no < 4) ? phase_no[1:0] : 2'($urandom_range(0, 3));
      fmt  = (mode == MODE_DART_ALT) ? MODE_DART : mode;
      write_mode(mode);
      quiet_run = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) begin
        put_random_frame(fmt);
        send_frame();
      end
      phase_no++;
    end

    quiet_run = 1'b0;
    settle();
    if (mismatch_count == 0 && results_pending == 0)
      $display("PASS serial_frame_parser_three_mode");
    else
      $display("FAIL serial_frame_parser_three_mode");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/sfp_pkg.sv
hdl/sfp_rx_if.sv
hdl/sfp_res_if.sv
hdl/sfp_emitter.sv
hdl/serial_frame_parser_three_mode.sv
bench/sfp_frame_checker.sv
bench/serial_frame_parser_three_mode_tb.sv
